### rtl/core/artdmx_universe_receiver_macros.svh
// Assertion macros for the ArtDmx universe receiver.
// No dependencies; the including module must have clk_i and rst_ni.
`ifndef ARTDMX_UNIVERSE_RECEIVER_MACROS_SVH
`define ARTDMX_UNIVERSE_RECEIVER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ARTDMX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ARTDMX_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/core/artdmx_pkg.sv
// Shared types and constants of the ArtDmx universe receiver.
// No dependencies.
package artdmx_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_BAD_ID     = 3'd2,
    ST_OTHER_OP   = 3'd3,
    ST_NO_DATA    = 3'd4,
    ST_TABLE_FULL = 3'd5
  } status_e;

  localparam logic [15:0] OP_DMX  = 16'h5000;
  localparam logic [10:0] HDR_LEN = 11'd18;
  localparam logic [10:0] POS_MAX = 11'd2047;
  localparam logic [6:0]  RUN_MAX = 7'd64;

  typedef struct packed {
    logic [9:0]  len;
    logic [7:0]  seq;
    logic [31:0] packets;
    logic [31:0] drops;
  } slot_stats_t;

  // "Art-Net" followed by a zero byte
  function automatic logic [7:0] art_id(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h41;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h2d;
      3'd4:    c = 8'h4e;
      3'd5:    c = 8'h65;
      3'd6:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/artdmx_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module artdmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/artdmx_universe_receiver.sv
// ArtDmx universe receiver: datagram bytes in at one per cycle while in_stall_o is low;
// the status result of a datagram passes the parse stage, then the store compare/write
// stage, into the output register. A read run does a slot-statistics fetch, then per
// reply a channel memory read and an output load; input is stalled meanwhile.
// Reset (async, active low) clears slot valid bits, bounds and parse counters at once and
// sets the version count to 1; channel memory and statistics memory have no clearing pass.
// Depends on artdmx_pkg, artdmx_ram and artdmx_universe_receiver_macros.svh.
`include "artdmx_universe_receiver_macros.svh"

module artdmx_universe_receiver import artdmx_pkg::*; #(
  parameter int UNIVERSE_SLOTS = 8,
  parameter int MAX_CHANNELS   = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [14:0] query_address_i,
  input  logic [9:0]  query_channel_i,
  input  logic [6:0]  read_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [2:0]  status_o,
  output logic [14:0] universe_address_o,
  output logic        data_changed_o,
  output logic [31:0] version_count_o,
  output logic        found_o,
  output logic [7:0]  channel_value_o,
  output logic [9:0]  channel_count_o,
  output logic [31:0] packet_count_o,
  output logic [31:0] drop_count_o,
  output logic        last_result_o
);

  localparam int SW       = UNIVERSE_SLOTS > 1 ? $clog2(UNIVERSE_SLOTS) : 1;
  localparam int CH_DEPTH = UNIVERSE_SLOTS * MAX_CHANNELS;
  localparam int CH_AW    = CH_DEPTH > 1 ? $clog2(CH_DEPTH) : 1;
  localparam int STATS_W  = $bits(slot_stats_t);

  typedef enum logic [1:0] {RUN_IDLE, RUN_STAT, RUN_REQ, RUN_WAIT} run_e;

  // ---------------------------------------------------------------- handshakes
  logic in_fire, byte_fire, read_fire, out_free;
  logic s2_hold, s2_adv;
  run_e run_st_q;

  // stage 2 (compare/write) registers
  logic             s2_v_q, s2_wr_q, s2_oldv_q, s2_last_q, s2_ok_q, s2_fresh_q;
  logic [CH_AW-1:0] s2_addr_q;
  logic [7:0]       s2_byte_q, s2_seq_q;
  status_e          s2_status_q;
  logic [14:0]      s2_uaddr_q;
  logic [SW-1:0]    s2_slot_q;
  logic [9:0]       s2_len_q;

  logic out_valid_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_hold    = s2_v_q && s2_last_q && !out_free;
  assign s2_adv     = s2_v_q && !s2_hold;
  // Input waits while a read run owns the memories or a status result cannot leave.
  assign in_stall_o = (run_st_q != RUN_IDLE) || s2_hold;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign byte_fire  = in_fire && !action_i;
  assign read_fire  = in_fire && action_i;

  // ---------------------------------------------------------------- slot table
  logic              slot_valid_q [UNIVERSE_SLOTS];
  logic [14:0]       slot_addr_q  [UNIVERSE_SLOTS];
  logic [9:0]        slot_wbound_q[UNIVERSE_SLOTS]; // channel bytes written so far
  logic              slot_fresh_q [UNIVERSE_SLOTS]; // allocated, statistics not yet written

  // ---------------------------------------------------------------- datagram parse state
  logic [10:0] pos_q;
  status_e     parse_q;
  logic [7:0]  seq_q, addr_lo_q, addr_hi_q, len_hi_q, len_lo_q, op_lo_q;
  logic [SW-1:0] cur_slot_q;
  logic        accepted_q, full_q, chg_q;
  logic [31:0] version_q;

  // stage 1 combinational view after taking this byte
  status_e     parse_nx;
  logic [7:0]  seq_nx, addr_lo_nx, addr_hi_nx, len_hi_nx, len_lo_nx, op_lo_nx;
  logic [14:0] uaddr_nx;
  logic [15:0] raw_len;
  logic [9:0]  clip_nx;
  logic        hit_any, free_any, take, alloc, acc_nx, full_nx;
  logic [SW-1:0] hit_idx, free_idx, slot_nx;
  logic [10:0] idx, n_cnt, n_data, lenr;
  logic [9:0]  wbound;
  logic        wr, oldv, fin_ok, fresh_nx;
  status_e     fin_status;

  always_comb begin
    parse_nx   = parse_q;
    seq_nx     = seq_q;
    addr_lo_nx = addr_lo_q;
    addr_hi_nx = addr_hi_q;
    len_hi_nx  = len_hi_q;
    len_lo_nx  = len_lo_q;
    op_lo_nx   = op_lo_q;
    if (pos_q < 11'd8) begin
      if (data_byte_i != art_id(pos_q[2:0])) parse_nx = ST_BAD_ID;
    end
    case (pos_q)
      11'd8:  op_lo_nx = data_byte_i;
      11'd9:  if ({data_byte_i, op_lo_q} != OP_DMX && parse_q == ST_OK) parse_nx = ST_OTHER_OP;
      11'd12: seq_nx = data_byte_i;
      11'd14: addr_lo_nx = data_byte_i;
      11'd15: addr_hi_nx = data_byte_i;
      11'd16: len_hi_nx = data_byte_i;
      11'd17: len_lo_nx = data_byte_i;
      default: ;
    endcase
    uaddr_nx = {addr_hi_nx[6:0], addr_lo_nx};
    raw_len  = {len_hi_nx, len_lo_nx};
    clip_nx  = (raw_len > 16'(MAX_CHANNELS)) ? 10'(MAX_CHANNELS) : raw_len[9:0];

    // slot search, lowest index wins
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = UNIVERSE_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid_q[i] && slot_addr_q[i] == uaddr_nx) begin
        hit_any = 1'b1;
        hit_idx = SW'(i);
      end
      if (!slot_valid_q[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end

    take    = (pos_q == HDR_LEN) && (parse_nx == ST_OK) && (clip_nx != 10'd0);
    alloc   = take && !hit_any && free_any;
    full_nx = full_q || (take && !hit_any && !free_any);
    acc_nx  = accepted_q || (take && (hit_any || free_any));
    slot_nx = (take && hit_any) ? hit_idx : (alloc ? free_idx : cur_slot_q);

    idx    = pos_q - HDR_LEN;
    wr     = acc_nx && (pos_q >= HDR_LEN) && (idx < {1'b0, clip_nx});
    wbound = alloc ? 10'd0 : slot_wbound_q[slot_nx];
    oldv   = idx < {1'b0, wbound};

    // end of datagram
    n_cnt  = (pos_q == POS_MAX) ? POS_MAX : pos_q + 11'd1;
    n_data = n_cnt - HDR_LEN;
    lenr   = (n_data < {1'b0, clip_nx}) ? n_data : {1'b0, clip_nx};
    if (n_cnt < HDR_LEN)           fin_status = ST_SHORT;
    else if (parse_nx != ST_OK)    fin_status = parse_nx;
    else if (lenr == 11'd0)        fin_status = ST_NO_DATA;
    else if (full_nx || !acc_nx)   fin_status = ST_TABLE_FULL;
    else                           fin_status = ST_OK;
    fin_ok   = (fin_status == ST_OK);
    fresh_nx = alloc || slot_fresh_q[slot_nx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      parse_q    <= ST_OK;
      seq_q      <= '0;
      addr_lo_q  <= '0;
      addr_hi_q  <= '0;
      len_hi_q   <= '0;
      len_lo_q   <= '0;
      op_lo_q    <= '0;
      cur_slot_q <= '0;
      accepted_q <= 1'b0;
      full_q     <= 1'b0;
      for (int i = 0; i < UNIVERSE_SLOTS; i++) begin
        slot_valid_q[i]  <= 1'b0;
        slot_wbound_q[i] <= '0;
        slot_fresh_q[i]  <= 1'b0;
      end
    end else begin
      if (byte_fire) begin
        if (last_byte_i) begin
          pos_q      <= '0;
          parse_q    <= ST_OK;
          seq_q      <= '0;
          addr_lo_q  <= '0;
          addr_hi_q  <= '0;
          len_hi_q   <= '0;
          len_lo_q   <= '0;
          op_lo_q    <= '0;
          cur_slot_q <= '0;
          accepted_q <= 1'b0;
          full_q     <= 1'b0;
        end else begin
          pos_q      <= n_cnt;
          parse_q    <= parse_nx;
          seq_q      <= seq_nx;
          addr_lo_q  <= addr_lo_nx;
          addr_hi_q  <= addr_hi_nx;
          len_hi_q   <= len_hi_nx;
          len_lo_q   <= len_lo_nx;
          op_lo_q    <= op_lo_nx;
          cur_slot_q <= slot_nx;
          accepted_q <= acc_nx;
          full_q     <= full_nx;
        end
        if (alloc) begin
          slot_valid_q[free_idx]  <= 1'b1;
          slot_fresh_q[free_idx]  <= 1'b1;
        end
        // a new slot starts from zero, raised by the first byte written
        if (wr && !oldv) begin
          slot_wbound_q[slot_nx] <= 10'(idx + 11'd1);
        end else if (alloc) begin
          slot_wbound_q[free_idx] <= '0;
        end
      end
      // statistics written back: slot no longer reads as zero
      if (s2_adv && s2_last_q && s2_ok_q) begin
        slot_fresh_q[s2_slot_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_fire && alloc) begin
      slot_addr_q[free_idx] <= uaddr_nx;
    end
  end

  // ---------------------------------------------------------------- memories
  logic             ch_we, ch_re;
  logic [CH_AW-1:0] ch_waddr, ch_raddr, byte_addr, run_addr;
  logic [7:0]       ch_rdata;
  logic             st_we, st_re;
  logic [SW-1:0]    st_raddr;
  slot_stats_t      st_rdata, st_wdata;
  logic [STATS_W-1:0] st_rbits;

  artdmx_ram #(.WIDTH(8), .DEPTH(CH_DEPTH)) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_waddr),
    .wdata_i (s2_byte_q),
    .re_i    (ch_re),
    .raddr_i (ch_raddr),
    .rdata_o (ch_rdata)
  );

  artdmx_ram #(.WIDTH(STATS_W), .DEPTH(UNIVERSE_SLOTS)) u_stats_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (s2_slot_q),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rbits)
  );
  assign st_rdata = slot_stats_t'(st_rbits);

  // ---------------------------------------------------------------- stage 2
  logic [7:0]  old_byte;
  logic        diff, fin_changed, gap;
  logic [7:0]  expect_seq;
  slot_stats_t old_st;

  assign byte_addr = CH_AW'(int'(slot_nx) * MAX_CHANNELS + int'(idx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q    <= 1'b0;
      chg_q     <= 1'b0;
      version_q <= 32'd1;
    end else begin
      if (byte_fire) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv) begin
        chg_q <= s2_last_q ? 1'b0 : (chg_q | diff);
        if (fin_changed) version_q <= version_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_fire) begin
      s2_wr_q     <= wr;
      s2_oldv_q   <= oldv;
      s2_addr_q   <= byte_addr;
      s2_byte_q   <= data_byte_i;
      s2_last_q   <= last_byte_i;
      s2_ok_q     <= fin_ok;
      s2_status_q <= fin_status;
      s2_uaddr_q  <= uaddr_nx;
      s2_slot_q   <= slot_nx;
      s2_seq_q    <= seq_nx;
      s2_len_q    <= lenr[9:0];
      s2_fresh_q  <= fresh_nx;
    end
  end

  always_comb begin
    old_byte    = s2_oldv_q ? ch_rdata : 8'd0;
    diff        = s2_wr_q && (old_byte != s2_byte_q);
    fin_changed = s2_last_q && s2_ok_q && (chg_q || diff);
    old_st      = s2_fresh_q ? '0 : st_rdata;
    // sequence 255 is followed by 1
    expect_seq  = (old_st.seq == 8'd255) ? 8'd1 : old_st.seq + 8'd1;
    gap         = (s2_seq_q != 8'd0) && (old_st.seq != 8'd0) && (s2_seq_q != expect_seq);
    st_wdata.len     = s2_len_q;
    st_wdata.seq     = s2_seq_q;
    st_wdata.packets = (old_st.packets == '1) ? old_st.packets : old_st.packets + 32'd1;
    st_wdata.drops   = (gap && old_st.drops != '1) ? old_st.drops + 32'd1 : old_st.drops;
  end

  assign ch_we    = s2_adv && s2_wr_q;
  assign ch_waddr = s2_addr_q;
  assign st_we    = s2_adv && s2_last_q && s2_ok_q;

  // ---------------------------------------------------------------- read run
  logic [14:0]   r_addr_q;
  logic [10:0]   r_base_q;
  logic [6:0]    r_cnt_q, r_k_q, cnt_nx;
  logic          r_nz_q, r_found_q, r_cond_q;
  logic [SW-1:0] r_slot_q;
  logic          q_hit;
  logic [SW-1:0] q_idx;
  logic [10:0]   ch;
  logic [9:0]    r_len;
  logic [31:0]   r_pkt, r_drop;
  logic          r_cond, r_issue, r_last;

  always_comb begin
    q_hit = 1'b0;
    q_idx = '0;
    for (int i = UNIVERSE_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid_q[i] && slot_addr_q[i] == query_address_i) begin
        q_hit = 1'b1;
        q_idx = SW'(i);
      end
    end
    if (read_count_i == 7'd0)     cnt_nx = 7'd1;
    else if (read_count_i > RUN_MAX) cnt_nx = RUN_MAX;
    else                          cnt_nx = read_count_i;

    // statistics stay on the stats RAM output for the whole run
    r_len  = (r_found_q && !slot_fresh_q[r_slot_q]) ? st_rdata.len : 10'd0;
    r_pkt  = (r_found_q && !slot_fresh_q[r_slot_q]) ? st_rdata.packets : 32'd0;
    r_drop = (r_found_q && !slot_fresh_q[r_slot_q]) ? st_rdata.drops : 32'd0;
    ch     = r_base_q + {4'd0, r_k_q};
    r_cond = r_found_q && r_nz_q && (ch != 11'd0) && (ch <= {1'b0, r_len}) &&
             (ch <= 11'(MAX_CHANNELS));
    run_addr = CH_AW'(int'(r_slot_q) * MAX_CHANNELS + int'(ch) - 1);
    r_issue  = (run_st_q == RUN_REQ) && out_free;
    r_last   = (r_k_q + 7'd1 == r_cnt_q);
  end

  assign ch_re    = (byte_fire && wr) || r_issue;
  assign ch_raddr = r_issue ? run_addr : byte_addr;
  assign st_re    = (byte_fire && last_byte_i && fin_ok) || (run_st_q == RUN_STAT);
  assign st_raddr = (run_st_q == RUN_STAT) ? r_slot_q : slot_nx;

  // ---------------------------------------------------------------- run FSM + output register
  logic        out_kind_q, out_changed_q, out_found_q, out_last_q;
  status_e     out_status_q;
  logic [14:0] out_addr_q;
  logic [31:0] out_version_q, out_pkt_q, out_drop_q;
  logic [7:0]  out_value_q;
  logic [9:0]  out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_st_q    <= RUN_IDLE;
      out_valid_q <= 1'b0;
      r_k_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (run_st_q)
        RUN_IDLE: begin
          r_k_q <= '0;
          if (read_fire) run_st_q <= RUN_STAT;
        end
        RUN_STAT: run_st_q <= RUN_REQ;
        RUN_REQ:  if (r_issue) run_st_q <= RUN_WAIT;
        RUN_WAIT: begin
          out_valid_q <= 1'b1;
          if (r_last) begin
            run_st_q <= RUN_IDLE;
          end else begin
            r_k_q    <= r_k_q + 7'd1;
            run_st_q <= RUN_REQ;
          end
        end
        default: run_st_q <= RUN_IDLE;
      endcase
      if (s2_adv && s2_last_q) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (read_fire) begin
      r_addr_q  <= query_address_i;
      r_base_q  <= {1'b0, query_channel_i};
      r_cnt_q   <= cnt_nx;
      r_nz_q    <= (read_count_i != 7'd0);
      r_found_q <= q_hit;
      r_slot_q  <= q_idx;
    end
    if (r_issue) r_cond_q <= r_cond;
    if (run_st_q == RUN_WAIT) begin
      out_kind_q    <= 1'b1;
      out_status_q  <= r_found_q ? ST_OK : ST_NO_DATA;
      out_addr_q    <= r_addr_q;
      out_changed_q <= 1'b0;
      out_version_q <= version_q;
      out_found_q   <= r_found_q;
      out_value_q   <= r_cond_q ? ch_rdata : 8'd0;
      out_count_q   <= r_len;
      out_pkt_q     <= r_pkt;
      out_drop_q    <= r_drop;
      out_last_q    <= r_last;
    end else if (s2_adv && s2_last_q) begin
      out_kind_q    <= 1'b0;
      out_status_q  <= s2_status_q;
      out_addr_q    <= s2_uaddr_q;
      out_changed_q <= fin_changed;
      out_version_q <= fin_changed ? version_q + 32'd1 : version_q;
      out_found_q   <= 1'b0;
      out_value_q   <= 8'd0;
      out_count_q   <= 10'd0;
      out_pkt_q     <= 32'd0;
      out_drop_q    <= 32'd0;
      out_last_q    <= 1'b1;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = out_kind_q;
  assign status_o           = out_status_q;
  assign universe_address_o = out_addr_q;
  assign data_changed_o     = out_changed_q;
  assign version_count_o    = out_version_q;
  assign found_o            = out_found_q;
  assign channel_value_o    = out_value_q;
  assign channel_count_o    = out_count_q;
  assign packet_count_o     = out_pkt_q;
  assign drop_count_o       = out_drop_q;
  assign last_result_o      = out_last_q;

  // ---------------------------------------------------------------- assertions
  `ARTDMX_ASSERT(a_wait_out_empty, (run_st_q == RUN_WAIT) |-> !out_valid_q, "reply would overwrite result")
  `ARTDMX_ASSERT_NEVER(a_run_vs_status, (run_st_q != RUN_IDLE) && s2_v_q && s2_last_q, "status pending in run")
  `ARTDMX_ASSERT(a_version_step, (version_q != $past(version_q)) |-> (version_q == $past(version_q) + 32'd1), "version jump")
  `ARTDMX_ASSERT(a_status_last, (out_valid_q && !out_kind_q) |-> out_last_q, "status result not last")

endmodule
